[src/page_framebuffer_dirty_flush_assert.svh]
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_flush_assert.svh
// Assertion macros for the frame buffer top module
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DIRTY_FLUSH_ASSERT_SVH
`define PAGE_FRAMEBUFFER_DIRTY_FLUSH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PFDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pfdf_pkg.sv]
// ----------------------------------------------------------------------------
// pfdf_pkg
// Shared sizes, codes, types and helpers of the page frame buffer
// ----------------------------------------------------------------------------
package pfdf_pkg;

    // geometry
    localparam int COLUMNS = 128;
    localparam int PAGES   = 4;
    localparam int ROWS    = PAGES * 8;
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;

    // command codes
    typedef enum logic [2:0] {
        CMD_POINT   = 3'd0,
        CMD_RECT    = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_SERVICE = 3'd3,
        CMD_READ    = 3'd4,
        CMD_REFAIL  = 3'd5
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ERR  = 2'd1,
        STATUS_MORE = 2'd2
    } status_t;

    // store port request, one column word per beat
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic             clr;
        logic [COL_W-1:0] addr;
        logic [ROWS-1:0]  wdata;
    } store_req_t;

    // dirty tracker request
    typedef struct packed {
        logic             mark;
        logic             set_all;
        logic             service;
        logic             refail;
        logic [PAGES-1:0] mark_pages;
    } dirty_req_t;

    // service choice seen by the sequencer
    typedef struct packed {
        logic            found;
        logic            remain;
        logic [PG_W-1:0] first;
        logic [PG_W-1:0] last;
    } dirty_rsp_t;

    // pages touched by a row mask
    function automatic logic [PAGES-1:0] page_mask(input logic [ROWS-1:0] rows);
        logic [PAGES-1:0] m;
        m = '0;
        for (int p = 0; p < PAGES; p++) begin
            m[p] = |rows[p*8 +: 8];
        end
        return m;
    endfunction

    // contiguous page run from first to last
    function automatic logic [PAGES-1:0] run_mask(input logic [PG_W-1:0] first,
                                                  input logic [PG_W-1:0] last);
        logic [PAGES-1:0] m;
        m = '0;
        for (int p = 0; p < PAGES; p++) begin
            m[p] = (p >= int'(first)) && (p <= int'(last));
        end
        return m;
    endfunction

endpackage

[src/pfdf_store.sv]
// ----------------------------------------------------------------------------
// pfdf_store
// Column-word frame memory with per-column valid bits for instant clear
// ----------------------------------------------------------------------------
module pfdf_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfdf_pkg::store_req_t         req,
    output logic [pfdf_pkg::ROWS-1:0]    rdata
);

    localparam int Columns = pfdf_pkg::COLUMNS;
    localparam int Rows    = pfdf_pkg::ROWS;

    logic [Rows-1:0]    mem [Columns];
    logic [Rows-1:0]    rd_word_reg;
    logic               rd_hit_reg;
    logic [Columns-1:0] valid_reg;

    // memory array, one port used per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rd_word_reg <= mem[req.addr];
        end
    end

    // column valid bits, unwritten columns read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd)
            begin
                rd_hit_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = rd_hit_reg ? rd_word_reg : '0;

endmodule

[src/pfdf_dirty.sv]
// ----------------------------------------------------------------------------
// pfdf_dirty
// Dirty page mask, round-robin flush window search and last window record
// ----------------------------------------------------------------------------
module pfdf_dirty (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfdf_pkg::dirty_req_t          req,
    output pfdf_pkg::dirty_rsp_t          rsp,
    output logic [pfdf_pkg::PAGES-1:0]    dirty
);

    localparam int Pages = pfdf_pkg::PAGES;
    localparam int PgW   = pfdf_pkg::PG_W;

    logic [Pages-1:0] dirty_reg;
    logic [PgW-1:0]   next_reg;
    logic [PgW-1:0]   last_first_reg;
    logic [PgW-1:0]   last_last_reg;

    logic             found;
    logic             extend;
    logic [PgW-1:0]   first;
    logic [PgW-1:0]   last;
    logic [Pages-1:0] run;
    logic [PgW-1:0]   after_last;

    // first dirty page from the search pointer, then extend upward
    always_comb
    begin
        int p;
        found = 1'b0;
        first = '0;
        for (int i = 0; i < Pages; i++)
        begin
            p = int'(next_reg) + i;
            if (p >= Pages)
            begin
                p = p - Pages;
            end
            if (!found && dirty_reg[PgW'(p)])
            begin
                found = 1'b1;
                first = PgW'(p);
            end
        end
        last   = first;
        extend = found;
        for (int k = 1; k < Pages; k++)
        begin
            if (extend && (int'(first) + k < Pages) && dirty_reg[PgW'(int'(first) + k)])
            begin
                last = PgW'(int'(first) + k);
            end
            else
            begin
                extend = 1'b0;
            end
        end
    end

    assign run        = pfdf_pkg::run_mask(first, last);
    assign after_last = (int'(last) + 1 >= Pages) ? '0 : PgW'(int'(last) + 1);

    // dirty state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg      <= '1;
            next_reg       <= '0;
            last_first_reg <= '0;
            last_last_reg  <= '0;
        end
        else if (req.set_all)
        begin
            dirty_reg <= '1;
        end
        else if (req.mark)
        begin
            dirty_reg <= dirty_reg | req.mark_pages;
        end
        else if (req.refail)
        begin
            dirty_reg <= dirty_reg | pfdf_pkg::run_mask(last_first_reg, last_last_reg);
        end
        else if (req.service && found)
        begin
            dirty_reg      <= dirty_reg & ~run;
            last_first_reg <= first;
            last_last_reg  <= last;
            next_reg       <= after_last;
        end
    end

    assign rsp.found  = found;
    assign rsp.remain = |(dirty_reg & ~run);
    assign rsp.first  = first;
    assign rsp.last   = last;
    assign dirty      = dirty_reg;

endmodule

[src/page_framebuffer_dirty_flush.sv]
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_flush
// Page-organized monochrome frame buffer with dirty page flush control
// ----------------------------------------------------------------------------
// Sequence: clear, service, flush failed and errors go from accept straight to
// the result state; point and read pass the read and write states; a rectangle
// repeats read and write for each column, as its read-modify-write loop shares
// the single memory port. No new command is taken until idle after the result.
// Reset: store reads as zero at once through column valid bits, all pages
// dirty, no clearing sweep; results cannot be stalled by the receiver.
module page_framebuffer_dirty_flush (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] command,
    input  logic [7:0] x_left,
    input  logic [7:0] y_top,
    input  logic [7:0] x_right,
    input  logic [7:0] y_bottom,
    input  logic       color,
    input  logic [6:0] read_column,
    input  logic [1:0] read_page,
    output logic       done,
    output logic [1:0] status,
    output logic       window_valid,
    output logic [1:0] window_start,
    output logic [1:0] window_end,
    output logic [7:0] read_data,
    output logic [3:0] dirty_mask
);

    localparam int Columns = pfdf_pkg::COLUMNS;
    localparam int Pages   = pfdf_pkg::PAGES;
    localparam int Rows    = pfdf_pkg::ROWS;
    localparam int ColW    = pfdf_pkg::COL_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_WR   = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ColW-1:0] col_reg;
    logic [ColW-1:0] col_end_reg;
    logic [Rows-1:0] row_mask_reg;
    logic            color_reg;
    logic            op_read_reg;
    logic [1:0]      page_sel_reg;

    pfdf_pkg::status_t status_reg;
    logic              wvalid_reg;
    logic [1:0]        wstart_reg;
    logic [1:0]        wend_reg;
    logic [7:0]        rdata_reg;

    pfdf_pkg::store_req_t store_req;
    pfdf_pkg::dirty_req_t dirty_req;
    pfdf_pkg::dirty_rsp_t dirty_rsp;
    logic [Rows-1:0]      store_rdata;
    logic [Pages-1:0]     dirty;

    pfdf_pkg::cmd_t  cmd;
    logic            accept;
    logic            pt_bad;
    logic            rect_bad;
    logic            rd_bad;
    logic [7:0]      y_bot_clip;
    logic [7:0]      y_bot;
    logic [ColW-1:0] x_right_clip;
    logic [Rows-1:0] row_mask_new;
    logic            last_col;
    logic [Rows-1:0] merged;

    assign cmd    = pfdf_pkg::cmd_t'(command);
    assign accept = start && (state_reg == ST_IDLE);

    // command decode and range checks
    assign pt_bad   = ({1'b0, x_left} >= 9'(Columns)) || ({1'b0, y_top} >= 9'(Rows));
    assign rect_bad = pt_bad || (x_left > x_right) || (y_top > y_bottom);
    assign rd_bad   = ({2'b00, read_column} >= 9'(Columns)) || ({2'b00, read_page} >= 4'(Pages));

    assign y_bot_clip   = ({1'b0, y_bottom} >= 9'(Rows)) ? 8'(Rows - 1) : y_bottom;
    assign y_bot        = (cmd == pfdf_pkg::CMD_POINT) ? y_top : y_bot_clip;
    assign x_right_clip = ({1'b0, x_right} >= 9'(Columns)) ? ColW'(Columns - 1)
                                                           : ColW'(x_right);
    assign row_mask_new = ({Rows{1'b1}} << y_top) & ({Rows{1'b1}} >> (8'(Rows - 1) - y_bot));

    // shared read-modify-write unit
    assign merged   = color_reg ? (store_rdata | row_mask_reg) : (store_rdata & ~row_mask_reg);
    assign last_col = (col_reg == col_end_reg);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd == pfdf_pkg::CMD_POINT && !pt_bad) ||
                        (cmd == pfdf_pkg::CMD_RECT && !rect_bad) ||
                        (cmd == pfdf_pkg::CMD_READ && !rd_bad))
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RD:   state_next = ST_WR;
            ST_WR:   state_next = (op_read_reg || last_col) ? ST_RESP : ST_RD;
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // store and dirty tracker requests
    always_comb
    begin
        store_req       = '0;
        store_req.addr  = col_reg;
        store_req.wdata = merged;
        store_req.rd    = (state_reg == ST_RD);
        store_req.wr    = (state_reg == ST_WR) && !op_read_reg;
        store_req.clr   = accept && (cmd == pfdf_pkg::CMD_CLEAR);

        dirty_req            = '0;
        dirty_req.mark_pages = pfdf_pkg::page_mask(row_mask_reg);
        dirty_req.mark       = (state_reg == ST_WR) && !op_read_reg && last_col;
        dirty_req.set_all    = accept && (cmd == pfdf_pkg::CMD_CLEAR);
        dirty_req.service    = accept && (cmd == pfdf_pkg::CMD_SERVICE);
        dirty_req.refail     = accept && (cmd == pfdf_pkg::CMD_REFAIL);
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg    <= color;
            row_mask_reg <= row_mask_new;
            op_read_reg  <= (cmd == pfdf_pkg::CMD_READ);
            page_sel_reg <= read_page;
            col_reg      <= (cmd == pfdf_pkg::CMD_READ) ? ColW'(read_column) : ColW'(x_left);
            col_end_reg  <= (cmd == pfdf_pkg::CMD_POINT) ? ColW'(x_left) : x_right_clip;
            status_reg   <= pfdf_pkg::STATUS_OK;
            wvalid_reg   <= 1'b0;
            wstart_reg   <= '0;
            wend_reg     <= '0;
            rdata_reg    <= '0;
            case (cmd)
                pfdf_pkg::CMD_POINT:
                begin
                    if (pt_bad)
                    begin
                        status_reg <= pfdf_pkg::STATUS_ERR;
                    end
                end
                pfdf_pkg::CMD_RECT:
                begin
                    if (rect_bad)
                    begin
                        status_reg <= pfdf_pkg::STATUS_ERR;
                    end
                end
                pfdf_pkg::CMD_READ:
                begin
                    if (rd_bad)
                    begin
                        status_reg <= pfdf_pkg::STATUS_ERR;
                    end
                end
                pfdf_pkg::CMD_SERVICE:
                begin
                    if (dirty_rsp.found)
                    begin
                        wvalid_reg <= 1'b1;
                        wstart_reg <= 2'(dirty_rsp.first);
                        wend_reg   <= 2'(dirty_rsp.last);
                        if (dirty_rsp.remain)
                        begin
                            status_reg <= pfdf_pkg::STATUS_MORE;
                        end
                    end
                end
                pfdf_pkg::CMD_CLEAR, pfdf_pkg::CMD_REFAIL:
                begin
                    status_reg <= pfdf_pkg::STATUS_OK;
                end
                default:
                begin
                    status_reg <= pfdf_pkg::STATUS_ERR;
                end
            endcase
        end
        else if (state_reg == ST_WR)
        begin
            if (op_read_reg)
            begin
                rdata_reg <= 8'(store_rdata >> {page_sel_reg, 3'b000});
            end
            else if (!last_col)
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    pfdf_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .rdata (store_rdata)
    );

    pfdf_dirty u_dirty (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dirty_req),
        .rsp   (dirty_rsp),
        .dirty (dirty)
    );

    // result ports
    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_RESP);
    assign status       = status_reg;
    assign window_valid = wvalid_reg;
    assign window_start = wstart_reg;
    assign window_end   = wend_reg;
    assign read_data    = rdata_reg;
    assign dirty_mask   = 4'(dirty);

`include "page_framebuffer_dirty_flush_assert.svh"

    // sequencing and result checks
    `PFDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not go busy")
    `PFDF_ASSERT_NEXT(a_done_frees, done, !busy, "block still busy after result beat")
    `PFDF_ASSERT_SAME(a_done_in_cmd, done, busy, "result beat outside a command")
    `PFDF_ASSERT_SAME(a_window_ok, done && window_valid, status != pfdf_pkg::STATUS_ERR,
                      "flush window reported with error status")

endmodule
